### rtl/dhkt_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// dhkt_pkg
// Shared types, codes and constants of the double-hashed key table.
// ============================================================================
package dhkt_pkg;

    // Field widths of the request and response channels.
    localparam int KIND_W = 3;
    localparam int KEY_W  = 31;
    localparam int RANK_W = 9;
    localparam int STAT_W = 3;
    localparam int SLOT_W = 8;

    // Default table size and hash constants.
    localparam int SLOTS_LOG2_DEF = 8;
    localparam int HASH_SEED      = 5381;
    localparam int DJB_SHIFT      = 5;
    localparam int SDBM_LO        = 6;
    localparam int SDBM_HI        = 16;

    // Decimal conversion of a key: ten digits of four bits.
    localparam int DIGITS = 10;
    localparam int BCD_W  = 4 * DIGITS;
    localparam int ASCII_ZERO = 48;

    // Memory word: mark over key.
    localparam int MARK_W = 2;
    localparam int WORD_W = MARK_W + KEY_W;

    typedef enum logic [KIND_W-1:0] {
        KIND_LOOKUP = 3'd0,
        KIND_INSERT = 3'd1,
        KIND_DELETE = 3'd2,
        KIND_CHANGE = 3'd3,
        KIND_NTH    = 3'd4,
        KIND_CLEAR  = 3'd5
    } t_kind;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK         = 3'd0,
        STAT_EMPTY      = 3'd1,
        STAT_NOTFOUND   = 3'd2,
        STAT_EXISTS     = 3'd3,
        STAT_ERROR      = 3'd4,
        STAT_NOTADDED   = 3'd5,
        STAT_NOTCHANGED = 3'd6
    } t_status;

    typedef enum logic [MARK_W-1:0] {
        MARK_FREE = 2'd0,
        MARK_USED = 2'd1,
        MARK_GONE = 2'd2
    } t_mark;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    load_req;
        logic    hash_start;
        logic    hash_new;
        logic    probe_init;
        logic    step_loc;
        logic    step_ins;
        logic    scan_init;
        logic    scan_step;
        logic    clr_init;
        logic    clr_step;
        logic    live_clear;
        logic    wr_used;
        logic    wr_gone_x;
        logic    wr_gone_old;
        logic    save_old;
        logic    res_set;
        t_status res_status;
        logic    res_slot_x;
        logic    res_fk;
        logic    out_load;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic hash_done;
        logic live_zero;
        logic live_full;
        logic rank_zero;
        logic rank_big;
        logic mark_free;
        logic mark_used;
        logic key_match;
        logic loc_over;
        logic ins_over;
        logic x_last;
        logic cnt_hit;
        logic out_busy;
    } t_sts;

endpackage

### rtl/dhkt_if.sv
`timescale 1ns / 1ps
// ============================================================================
// dhkt_if
// Valid/ready channels for requests and responses of the key table.
// ============================================================================
interface dhkt_req_if import dhkt_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic [KEY_W-1:0]  key;
    logic [KEY_W-1:0]  new_key;
    logic [RANK_W-1:0] rank;

    modport source (output valid, kind, key, new_key, rank, input ready);
    modport sink   (input valid, kind, key, new_key, rank, output ready);
endinterface

interface dhkt_rsp_if import dhkt_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [STAT_W-1:0] status;
    logic [SLOT_W-1:0] slot;
    logic [KEY_W-1:0]  found_key;
    logic              is_empty;

    modport source (output valid, status, slot, found_key, is_empty, input ready);
    modport sink   (input valid, status, slot, found_key, is_empty, output ready);
endinterface

### rtl/dhkt_ram.sv
`timescale 1ns / 1ps
// ============================================================================
// dhkt_ram
// Single-port RAM with one write and one registered read per cycle.
// ============================================================================
module dhkt_ram #(
    parameter int WIDTH      = 8,
    parameter int DEPTH_LOG2 = 8
) (
    input  logic                  i_clk,
    input  logic                  i_we,
    input  logic [DEPTH_LOG2-1:0] i_addr,
    input  logic [WIDTH-1:0]      i_wdata,
    output logic [WIDTH-1:0]      o_rdata
);
    logic [WIDTH-1:0] r_mem [(1 << DEPTH_LOG2)];
    logic [WIDTH-1:0] r_rdata;

    // Read before write: a read of the slot being written returns the old contents.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;
endmodule

### rtl/dhkt_hash.sv
`timescale 1ns / 1ps
// ============================================================================
// dhkt_hash
// Iterative hash unit: converts a key to decimal one bit per cycle, then
// folds one digit per cycle into the djb2 home and the sdbm step.
// ============================================================================
module dhkt_hash import dhkt_pkg::*; #(
    parameter int SLOTS_LOG2 = SLOTS_LOG2_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [KEY_W-1:0]      i_key,
    output logic                  o_done,
    output logic [SLOTS_LOG2-1:0] o_home,
    output logic [SLOTS_LOG2-1:0] o_step
);
    typedef enum logic [3:0] {
        HS_IDLE = 4'b0001,
        HS_CONV = 4'b0010,
        HS_DIG  = 4'b0100,
        HS_DONE = 4'b1000
    } t_hstate;

    t_hstate                 r_state, n_state;
    logic [4:0]              r_cnt, n_cnt;
    logic [KEY_W-1:0]        r_bin, n_bin;
    logic [BCD_W-1:0]        r_bcd, n_bcd;
    logic [SLOTS_LOG2-1:0]   r_a, n_a;
    logic [SLOTS_LOG2-1:0]   r_b, n_b;
    logic                    r_started, n_started;
    logic [BCD_W-1:0]        bcd_adj;
    logic [3:0]              dig;
    logic [5:0]              chr;
    logic [SLOTS_LOG2-1:0]   chr_s;

    // Add three to every digit of five or more before the next shift.
    always_comb begin
        for (int i = 0; i < DIGITS; i++) begin
            bcd_adj[4*i +: 4] = (r_bcd[4*i +: 4] >= 4'd5) ?
                                4'(r_bcd[4*i +: 4] + 4'd3) : r_bcd[4*i +: 4];
        end
    end

    assign dig   = r_bcd[BCD_W-1 -: 4];
    assign chr   = 6'(ASCII_ZERO) + 6'(dig);
    assign chr_s = SLOTS_LOG2'(chr);

    // Sequencing of conversion and digit folding.
    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        n_bin     = r_bin;
        n_bcd     = r_bcd;
        n_a       = r_a;
        n_b       = r_b;
        n_started = r_started;
        case (r_state)
            HS_IDLE: begin
                if (i_start) begin
                    n_state   = HS_CONV;
                    n_cnt     = 5'(KEY_W - 1);
                    n_bin     = i_key;
                    n_bcd     = '0;
                    n_a       = SLOTS_LOG2'(HASH_SEED);
                    n_b       = '0;
                    n_started = 1'b0;
                end
            end
            HS_CONV: begin
                n_bcd = {bcd_adj[BCD_W-2:0], r_bin[KEY_W-1]};
                n_bin = {r_bin[KEY_W-2:0], 1'b0};
                n_cnt = r_cnt - 5'd1;
                if (r_cnt == 5'd0) begin
                    n_state = HS_DIG;
                    n_cnt   = 5'(DIGITS - 1);
                end
            end
            HS_DIG: begin
                // Leading zeros are skipped; a zero key still hashes "0".
                if (r_started || (dig != 4'd0) || (r_cnt == 5'd0)) begin
                    n_a = r_a + (r_a << DJB_SHIFT) + chr_s;
                    n_b = (r_b << SDBM_HI) + (r_b << SDBM_LO) - r_b + chr_s;
                    n_started = 1'b1;
                end
                n_bcd = {r_bcd[BCD_W-5:0], 4'd0};
                n_cnt = r_cnt - 5'd1;
                if (r_cnt == 5'd0) begin
                    n_state = HS_DONE;
                end
            end
            HS_DONE: begin
                n_state = HS_IDLE;
            end
            default: begin
                n_state = HS_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= HS_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_cnt     <= n_cnt;
        r_bin     <= n_bin;
        r_bcd     <= n_bcd;
        r_a       <= n_a;
        r_b       <= n_b;
        r_started <= n_started;
    end

    assign o_done = (r_state == HS_DONE);
    assign o_home = r_a;
    assign o_step = r_b;
endmodule

### rtl/dhkt_datapath.sv
`timescale 1ns / 1ps
// ============================================================================
// dhkt_datapath
// Request registers, probe position, slot memory, live count and the
// result register of the key table.
// ============================================================================
module dhkt_datapath import dhkt_pkg::*; #(
    parameter int SLOTS_LOG2 = SLOTS_LOG2_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    output t_sts              o_sts,
    input  logic [KIND_W-1:0] i_kind,
    input  logic [KEY_W-1:0]  i_key,
    input  logic [KEY_W-1:0]  i_new_key,
    input  logic [RANK_W-1:0] i_rank,
    input  logic              i_out_ready,
    output logic              o_out_valid,
    output logic [STAT_W-1:0] o_status,
    output logic [SLOT_W-1:0] o_slot,
    output logic [KEY_W-1:0]  o_found_key,
    output logic              o_is_empty
);
    localparam int SL    = SLOTS_LOG2;
    localparam int SLOTS = 1 << SL;
    localparam int FILL  = (SLOTS >> 1) + (SLOTS >> 2);
    localparam int CNT_W = (SL + 1 > RANK_W) ? SL + 1 : RANK_W;
    localparam logic [SL+1:0] IT_LOC_MAX = (SL+2)'(2 * SLOTS);
    localparam logic [SL+1:0] IT_INS_MAX = (SL+2)'(SLOTS);

    logic [KIND_W-1:0] r_kind;
    logic [KEY_W-1:0]  r_key, r_new_key, r_cur_key;
    logic [RANK_W-1:0] r_rank;
    logic [SL-1:0]     r_x, r_inc, r_old;
    logic [SL+1:0]     r_it;
    logic [SL:0]       r_cnt, r_live;
    t_status           r_res_status;
    logic [SLOT_W-1:0] r_res_slot;
    logic [KEY_W-1:0]  r_res_fk;
    logic              r_out_valid;
    logic [STAT_W-1:0] r_out_status;
    logic [SLOT_W-1:0] r_out_slot;
    logic [KEY_W-1:0]  r_out_fk;
    logic              r_out_empty;

    logic              hash_done;
    logic [SL-1:0]     home, step, inc_loc;
    logic              ram_we;
    logic [SL-1:0]     ram_addr;
    logic [WORD_W-1:0] ram_wdata, ram_rdata;
    logic [MARK_W-1:0] rd_mark;
    logic [KEY_W-1:0]  rd_key;
    logic [KEY_W-1:0]  hash_key;

    assign hash_key = i_cmd.hash_new ? r_new_key : r_key;

    dhkt_hash #(.SLOTS_LOG2(SL)) u_hash (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.hash_start),
        .i_key   (hash_key),
        .o_done  (hash_done),
        .o_home  (home),
        .o_step  (step)
    );

    // Slot memory: mark and key in one word.
    always_comb begin
        ram_we    = i_cmd.wr_used | i_cmd.wr_gone_x | i_cmd.wr_gone_old | i_cmd.clr_step;
        ram_addr  = i_cmd.wr_gone_old ? r_old : r_x;
        ram_wdata = {MARK_FREE, {KEY_W{1'b0}}};
        if (i_cmd.wr_used) begin
            ram_wdata = {MARK_USED, r_cur_key};
        end else if (i_cmd.wr_gone_x || i_cmd.wr_gone_old) begin
            ram_wdata = {MARK_GONE, r_cur_key};
        end
    end

    dhkt_ram #(.WIDTH(WORD_W), .DEPTH_LOG2(SL)) u_slots (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    assign rd_mark = ram_rdata[WORD_W-1 -: MARK_W];
    assign rd_key  = ram_rdata[KEY_W-1:0];
    assign inc_loc = r_inc + step;

    // Request, probe and count registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x    <= '0;
            r_live <= '0;
        end else begin
            if (i_cmd.probe_init) begin
                r_x <= home;
            end else if (i_cmd.step_loc) begin
                r_x <= r_x + inc_loc;
            end else if (i_cmd.step_ins) begin
                r_x <= r_x + r_inc;
            end else if (i_cmd.scan_init || i_cmd.clr_init) begin
                r_x <= '0;
            end else if (i_cmd.scan_step || i_cmd.clr_step) begin
                r_x <= r_x + SL'(1);
            end
            if (i_cmd.live_clear) begin
                r_live <= '0;
            end else if (i_cmd.wr_used) begin
                r_live <= r_live + (SL+1)'(1);
            end else if (i_cmd.wr_gone_x || i_cmd.wr_gone_old) begin
                r_live <= r_live - (SL+1)'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_req) begin
            r_kind    <= i_kind;
            r_key     <= i_key;
            r_new_key <= i_new_key;
            r_rank    <= i_rank;
        end
        if (i_cmd.hash_start) begin
            r_cur_key <= hash_key;
        end
        if (i_cmd.probe_init) begin
            r_inc <= '0;
            r_it  <= '0;
        end else if (i_cmd.step_loc) begin
            r_inc <= inc_loc;
            r_it  <= r_it + (SL+2)'(1);
        end else if (i_cmd.step_ins) begin
            r_inc <= r_inc + step;
            r_it  <= r_it + (SL+2)'(1);
        end
        if (i_cmd.save_old) begin
            r_old <= r_x;
        end
        if (i_cmd.scan_init) begin
            r_cnt <= '0;
        end else if (i_cmd.scan_step && (rd_mark == MARK_USED)) begin
            r_cnt <= r_cnt + (SL+1)'(1);
        end
        if (i_cmd.res_set) begin
            r_res_status <= i_cmd.res_status;
            r_res_slot   <= i_cmd.res_slot_x ? SLOT_W'(r_x) : '0;
            r_res_fk     <= i_cmd.res_fk ? rd_key : '0;
        end
    end

    // Output register: holds a result until the transfer completes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
        if (i_cmd.out_load) begin
            r_out_status <= r_res_status;
            r_out_slot   <= r_res_slot;
            r_out_fk     <= r_res_fk;
            r_out_empty  <= (r_live == '0);
        end
    end

    // Status toward the controller.
    always_comb begin
        o_sts.kind      = r_kind;
        o_sts.hash_done = hash_done;
        o_sts.live_zero = (r_live == '0);
        o_sts.live_full = (r_live >= (SL+1)'(FILL));
        o_sts.rank_zero = (r_rank == '0);
        o_sts.rank_big  = (CNT_W'(r_rank) > CNT_W'(r_live));
        o_sts.mark_free = (rd_mark == MARK_FREE);
        o_sts.mark_used = (rd_mark == MARK_USED);
        o_sts.key_match = (rd_key == r_cur_key);
        o_sts.loc_over  = (r_it > IT_LOC_MAX);
        o_sts.ins_over  = (r_it == IT_INS_MAX);
        o_sts.x_last    = &r_x;
        o_sts.cnt_hit   = ((CNT_W'(r_cnt) + CNT_W'(1)) == CNT_W'(r_rank));
        o_sts.out_busy  = r_out_valid && !i_out_ready;
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_out_status;
    assign o_slot      = r_out_slot;
    assign o_found_key = r_out_fk;
    assign o_is_empty  = r_out_empty;

    // The live count never passes the slot count.
    a_live_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_live <= (SL+1)'(SLOTS))
        else $error("live count above slot count");

    // A new entry is only written below the fill limit.
    a_fill_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.wr_used |-> (r_live < (SL+1)'(FILL)))
        else $error("insert past fill limit");

    // A result is never loaded over one that is still waiting.
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> !(r_out_valid && !i_out_ready))
        else $error("result register overrun");
endmodule

### rtl/dhkt_ctrl.sv
`timescale 1ns / 1ps
// ============================================================================
// dhkt_ctrl
// Controller of the key table: sequences hashing, probe walks, the rank
// scan and the clearing sweep for each request.
// ============================================================================
module dhkt_ctrl import dhkt_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);
    typedef enum logic [13:0] {
        ST_BOOT     = 14'b00000000000001,
        ST_IDLE     = 14'b00000000000010,
        ST_DISPATCH = 14'b00000000000100,
        ST_HASH     = 14'b00000000001000,
        ST_LOC_P    = 14'b00000000010000,
        ST_LOC_C    = 14'b00000000100000,
        ST_INS_GATE = 14'b00000001000000,
        ST_INS_P    = 14'b00000010000000,
        ST_INS_C    = 14'b00000100000000,
        ST_CHG_DEL  = 14'b00001000000000,
        ST_SCAN_P   = 14'b00010000000000,
        ST_SCAN_C   = 14'b00100000000000,
        ST_CLR      = 14'b01000000000000,
        ST_FINISH   = 14'b10000000000000
    } t_state;

    t_state r_state, n_state;
    logic   r_on_new, n_on_new;
    logic   is_ins, is_chg;

    assign is_ins = (i_sts.kind == KIND_INSERT);
    assign is_chg = (i_sts.kind == KIND_CHANGE);

    // Next state and commands.
    always_comb begin
        n_state  = r_state;
        n_on_new = r_on_new;
        o_cmd    = '0;
        o_cmd.res_status = STAT_ERROR;
        case (r_state)
            ST_BOOT: begin
                o_cmd.clr_step = 1'b1;
                if (i_sts.x_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_req = 1'b1;
                    n_on_new       = 1'b0;
                    n_state        = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                o_cmd.res_set = 1'b1;
                n_state       = ST_FINISH;
                case (i_sts.kind)
                    KIND_LOOKUP: begin
                        if (i_sts.live_zero) begin
                            o_cmd.res_status = STAT_EMPTY;
                        end else begin
                            o_cmd.res_set    = 1'b0;
                            o_cmd.hash_start = 1'b1;
                            n_state          = ST_HASH;
                        end
                    end
                    KIND_INSERT: begin
                        o_cmd.res_set    = 1'b0;
                        o_cmd.hash_start = 1'b1;
                        n_state          = ST_HASH;
                    end
                    KIND_DELETE, KIND_CHANGE: begin
                        if (i_sts.live_zero) begin
                            o_cmd.res_status = STAT_NOTFOUND;
                        end else begin
                            o_cmd.res_set    = 1'b0;
                            o_cmd.hash_start = 1'b1;
                            n_state          = ST_HASH;
                        end
                    end
                    KIND_NTH: begin
                        if (i_sts.live_zero) begin
                            o_cmd.res_status = STAT_EMPTY;
                        end else if (i_sts.rank_big) begin
                            o_cmd.res_status = STAT_ERROR;
                        end else if (i_sts.rank_zero) begin
                            o_cmd.res_status = STAT_NOTFOUND;
                        end else begin
                            o_cmd.res_set   = 1'b0;
                            o_cmd.scan_init = 1'b1;
                            n_state         = ST_SCAN_P;
                        end
                    end
                    KIND_CLEAR: begin
                        o_cmd.res_set  = 1'b0;
                        o_cmd.clr_init = 1'b1;
                        n_state        = ST_CLR;
                    end
                    default: begin
                        o_cmd.res_status = STAT_ERROR;
                    end
                endcase
            end
            ST_HASH: begin
                if (i_sts.hash_done) begin
                    if (i_sts.live_zero) begin
                        n_state = ST_INS_GATE;
                    end else begin
                        o_cmd.probe_init = 1'b1;
                        n_state          = ST_LOC_P;
                    end
                end
            end
            ST_LOC_P: begin
                n_state = ST_LOC_C;
            end
            ST_LOC_C: begin
                if (i_sts.mark_free || i_sts.loc_over) begin
                    // Key is not in the table.
                    if (is_ins || (is_chg && r_on_new)) begin
                        n_state = ST_INS_GATE;
                    end else begin
                        o_cmd.res_set    = 1'b1;
                        o_cmd.res_status = STAT_NOTFOUND;
                        n_state          = ST_FINISH;
                    end
                end else if (i_sts.mark_used && i_sts.key_match) begin
                    // Key found at the current position.
                    o_cmd.res_set = 1'b1;
                    n_state       = ST_FINISH;
                    if (is_ins || (is_chg && r_on_new)) begin
                        o_cmd.res_status = STAT_EXISTS;
                    end else if (is_chg) begin
                        o_cmd.res_set    = 1'b0;
                        o_cmd.save_old   = 1'b1;
                        o_cmd.hash_start = 1'b1;
                        o_cmd.hash_new   = 1'b1;
                        n_on_new         = 1'b1;
                        n_state          = ST_HASH;
                    end else begin
                        o_cmd.res_status = STAT_OK;
                        o_cmd.res_slot_x = 1'b1;
                        o_cmd.wr_gone_x  = (i_sts.kind == KIND_DELETE);
                    end
                end else begin
                    o_cmd.step_loc = 1'b1;
                    n_state        = ST_LOC_P;
                end
            end
            ST_INS_GATE: begin
                if (i_sts.live_full) begin
                    o_cmd.res_set    = 1'b1;
                    o_cmd.res_status = STAT_ERROR;
                    n_state          = ST_FINISH;
                end else begin
                    o_cmd.probe_init = 1'b1;
                    n_state          = ST_INS_P;
                end
            end
            ST_INS_P: begin
                n_state = ST_INS_C;
            end
            ST_INS_C: begin
                if (i_sts.ins_over) begin
                    o_cmd.res_set    = 1'b1;
                    o_cmd.res_status = is_chg ? STAT_NOTCHANGED : STAT_NOTADDED;
                    n_state          = ST_FINISH;
                end else if (!i_sts.mark_used) begin
                    o_cmd.wr_used    = 1'b1;
                    o_cmd.res_set    = 1'b1;
                    o_cmd.res_status = STAT_OK;
                    o_cmd.res_slot_x = 1'b1;
                    n_state          = is_chg ? ST_CHG_DEL : ST_FINISH;
                end else begin
                    o_cmd.step_ins = 1'b1;
                    n_state        = ST_INS_P;
                end
            end
            ST_CHG_DEL: begin
                // The old key still sits where the first walk found it.
                o_cmd.wr_gone_old = 1'b1;
                n_state           = ST_FINISH;
            end
            ST_SCAN_P: begin
                n_state = ST_SCAN_C;
            end
            ST_SCAN_C: begin
                if (i_sts.mark_used && i_sts.cnt_hit) begin
                    o_cmd.res_set    = 1'b1;
                    o_cmd.res_status = STAT_OK;
                    o_cmd.res_slot_x = 1'b1;
                    o_cmd.res_fk     = 1'b1;
                    n_state          = ST_FINISH;
                end else if (i_sts.x_last) begin
                    o_cmd.res_set    = 1'b1;
                    o_cmd.res_status = STAT_NOTFOUND;
                    n_state          = ST_FINISH;
                end else begin
                    o_cmd.scan_step = 1'b1;
                    n_state         = ST_SCAN_P;
                end
            end
            ST_CLR: begin
                o_cmd.clr_step = 1'b1;
                if (i_sts.x_last) begin
                    o_cmd.live_clear = 1'b1;
                    o_cmd.res_set    = 1'b1;
                    o_cmd.res_status = STAT_OK;
                    n_state          = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (!i_sts.out_busy) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_BOOT;
            r_on_new <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_on_new <= n_on_new;
        end
    end

    assign o_in_ready = (r_state == ST_IDLE);

    // An accepted request is decoded in the next cycle.
    a_accept_dispatch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == ST_DISPATCH))
        else $error("accepted request not dispatched");

    // The old slot is freed only after the new key was placed.
    a_chg_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.wr_gone_old |-> $past(o_cmd.wr_used))
        else $error("old key freed without insert");

    // Exactly one state bit is set.
    a_state_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state))
        else $error("controller state not one-hot");
endmodule

### rtl/double_hash_key_table.sv
`timescale 1ns / 1ps
// ============================================================================
// double_hash_key_table
// Open-addressing key table with double hashing over decimal key digits.
// ============================================================================
// Requests arrive on i_req (kind, key, new_key, rank) and each gives one
// response on o_rsp (status, slot, found_key, is_empty); both are
// valid/ready channels and a transfer happens when both are high.
// One request is worked on at a time. The hash unit converts the key
// from binary to decimal, then folds the digits and finishes, and every
// probe of the slot memory goes through its registered read port. A
// lookup or delete takes one hash and a lookup walk, an insert one hash,
// a lookup walk and an insert walk, a change two hash runs and three
// walks; get nth scans the slots in order and clear sweeps every slot.
// After reset the block sweeps every slot to free with i_req.ready low.
// A result waits in the output register while the receiver stalls; a new
// request is still taken and worked on, and its result is held back until
// the waiting one has been transferred.
// ============================================================================
module double_hash_key_table import dhkt_pkg::*; #(
    parameter int SLOTS_LOG2 = SLOTS_LOG2_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    dhkt_req_if.sink   i_req,
    dhkt_rsp_if.source o_rsp
);
    t_cmd cmd;
    t_sts sts;

    dhkt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (i_req.ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    dhkt_datapath #(.SLOTS_LOG2(SLOTS_LOG2)) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_kind      (i_req.kind),
        .i_key       (i_req.key),
        .i_new_key   (i_req.new_key),
        .i_rank      (i_req.rank),
        .i_out_ready (o_rsp.ready),
        .o_out_valid (o_rsp.valid),
        .o_status    (o_rsp.status),
        .o_slot      (o_rsp.slot),
        .o_found_key (o_rsp.found_key),
        .o_is_empty  (o_rsp.is_empty)
    );
endmodule

### tb/sv/double_hash_key_table_tb.sv
`timescale 1ns / 1ps
// ============================================================================
// double_hash_key_table_tb
// Self-checking bench for the double-hashed key table.
// ============================================================================
// A directed table of requests covers every kind, the empty table, rank
// extremes, tombstones and unused kinds; a random part follows with keys
// drawn mostly from a small pool so that hits, duplicates and deletes are
// frequent. A behavioral table model predicts each response, and every
// response transfer is compared field by field with the oldest prediction.
// ============================================================================
module double_hash_key_table_tb;
    import dhkt_pkg::*;

    localparam int NSLOT = 1 << SLOTS_LOG2_DEF;
    localparam int SMASK = NSLOT - 1;
    localparam int FILL_MAX = (NSLOT >> 1) + (NSLOT >> 2);
    localparam int N_RANDOM = 800;

    // One response as seen on the output channel.
    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [SLOT_W-1:0] slot;
        logic [KEY_W-1:0]  found_key;
        logic              is_empty;
    } t_rsp;

    // One directed row; chk marks an expected status typed in by hand.
    typedef struct {
        logic [KIND_W-1:0] kind;
        logic [KEY_W-1:0]  key;
        logic [KEY_W-1:0]  new_key;
        logic [RANK_W-1:0] rank;
        logic              chk;
        t_status           want;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    dhkt_req_if req_ch ();
    dhkt_rsp_if rsp_ch ();

    double_hash_key_table i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch.sink),
        .o_rsp   (rsp_ch.source)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Shadow copy of the table.
    t_mark            tbl_mark [NSLOT];
    logic [KEY_W-1:0] tbl_key  [NSLOT];
    int               tbl_live;

    t_rsp rsp_expected [$];
    int   mismatches = 0;
    int   rsp_hold = 0;
    logic rsp_calm = 1'b0;
    logic [KEY_W-1:0] key_pool [16];

    initial begin
        #200_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    // djb2 home slot and sdbm step over the decimal digits of a key.
    function automatic void key_hashes(input logic [KEY_W-1:0] k,
                                       output int home, output int stride);
        int unsigned digs [12];
        int unsigned a, b, v, c;
        int n;
        a = 5381;
        b = 0;
        v = k;
        n = 0;
        do begin
            digs[n] = 48 + v % 10;
            n++;
            v = v / 10;
        end while (v != 0);
        while (n > 0) begin
            n--;
            c = digs[n];
            a = (a << 5) + a + c;
            b = c + (b << 6) + (b << 16) - b;
        end
        home = a & SMASK;
        stride = b & SMASK;
    endfunction

    function automatic bit key_find(input logic [KEY_W-1:0] k, output int where);
        int x, y, it;
        key_hashes(k, x, y);
        it = 0;
        while (tbl_mark[x] != MARK_FREE && it <= 2 * NSLOT) begin
            if (tbl_mark[x] == MARK_USED && tbl_key[x] == k) begin
                where = x;
                return 1'b1;
            end
            it++;
            x = (x + it * y) & SMASK;
        end
        return 1'b0;
    endfunction

    function automatic t_status key_add(input logic [KEY_W-1:0] k, output int where);
        int x, y, w;
        if (tbl_live != 0 && key_find(k, w)) return STAT_EXISTS;
        if (tbl_live >= FILL_MAX) return STAT_ERROR;
        key_hashes(k, x, y);
        for (int i = 0; i < NSLOT; i++) begin
            if (tbl_mark[x] != MARK_USED) begin
                tbl_mark[x] = MARK_USED;
                tbl_key[x] = k;
                tbl_live++;
                where = x;
                return STAT_OK;
            end
            x = (x + i * y) & SMASK;
        end
        return STAT_NOTADDED;
    endfunction

    function automatic void table_wipe();
        foreach (tbl_mark[i]) begin
            tbl_mark[i] = MARK_FREE;
            tbl_key[i] = '0;
        end
        tbl_live = 0;
    endfunction

    // Applies one request to the shadow table and returns its response.
    function automatic t_rsp table_apply(input logic [KIND_W-1:0] kind,
                                         input logic [KEY_W-1:0] k,
                                         input logic [KEY_W-1:0] nk,
                                         input logic [RANK_W-1:0] rank);
        t_rsp r;
        t_status st;
        int w, d, cnt;
        st = STAT_ERROR;
        r = '0;
        w = 0;
        case (kind)
            KIND_LOOKUP: begin
                if (tbl_live == 0) st = STAT_EMPTY;
                else if (key_find(k, w)) begin
                    st = STAT_OK;
                    r.slot = SLOT_W'(w);
                end else st = STAT_NOTFOUND;
            end
            KIND_INSERT: begin
                st = key_add(k, w);
                if (st == STAT_OK) r.slot = SLOT_W'(w);
            end
            KIND_DELETE: begin
                if (tbl_live == 0 || !key_find(k, w)) st = STAT_NOTFOUND;
                else begin
                    tbl_mark[w] = MARK_GONE;
                    tbl_live--;
                    st = STAT_OK;
                    r.slot = SLOT_W'(w);
                end
            end
            KIND_CHANGE: begin
                if (tbl_live == 0 || !key_find(k, d)) st = STAT_NOTFOUND;
                else begin
                    st = key_add(nk, w);
                    if (st == STAT_NOTADDED) st = STAT_NOTCHANGED;
                    if (st == STAT_OK) begin
                        r.slot = SLOT_W'(w);
                        void'(key_find(k, d));
                        tbl_mark[d] = MARK_GONE;
                        tbl_live--;
                    end
                end
            end
            KIND_NTH: begin
                if (tbl_live == 0) st = STAT_EMPTY;
                else if (rank > tbl_live) st = STAT_ERROR;
                else begin
                    st = STAT_NOTFOUND;
                    cnt = 0;
                    for (int i = 0; i < NSLOT; i++) begin
                        if (tbl_mark[i] == MARK_USED) begin
                            cnt++;
                            if (cnt == rank) begin
                                st = STAT_OK;
                                r.slot = SLOT_W'(i);
                                r.found_key = tbl_key[i];
                                break;
                            end
                        end
                    end
                end
            end
            KIND_CLEAR: begin
                table_wipe();
                st = STAT_OK;
            end
            default: st = STAT_ERROR;
        endcase
        r.status = st;
        r.is_empty = (tbl_live == 0);
        return r;
    endfunction

    // Sends one request; the prediction is queued at the transfer edge.
    task automatic send_request(input t_row row, input bit allow_idle);
        t_rsp p;
        if (allow_idle && $urandom_range(0, 3) == 0) begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        req_ch.valid   <= 1'b1;
        req_ch.kind    <= row.kind;
        req_ch.key     <= row.key;
        req_ch.new_key <= row.new_key;
        req_ch.rank    <= row.rank;
        do @(posedge i_clk); while (!req_ch.ready);
        p = table_apply(row.kind, row.key, row.new_key, row.rank);
        if (row.chk && p.status != row.want && mismatches < 10)
            $display("directed row: expected status %0d, predictor gives %0d",
                     row.want, p.status);
        if (row.chk && p.status != row.want) mismatches++;
        rsp_expected.push_back(p);
    endtask

    function automatic t_row mk(input t_kind kind, input logic [KEY_W-1:0] k,
                                input logic [KEY_W-1:0] nk, input int rank,
                                input bit chk, input t_status want);
        t_row r;
        r.kind = kind;
        r.key = k;
        r.new_key = nk;
        r.rank = RANK_W'(rank);
        r.chk = chk;
        r.want = want;
        return r;
    endfunction

    // Receiver side: random stall bursts outside the calm phase; every transfer
    // is compared against the oldest prediction.
    always @(posedge i_clk) begin
        t_rsp got, want;
        if (!i_rst_n) begin
            rsp_ch.ready <= 1'b0;
        end else begin
            if (rsp_ch.valid && rsp_ch.ready) begin
                got = {rsp_ch.status, rsp_ch.slot, rsp_ch.found_key, rsp_ch.is_empty};
                if (rsp_expected.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("response transfer with none expected");
                end else begin
                    want = rsp_expected.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected st=%0d slot=%0d key=%0d empty=%0b, got st=%0d slot=%0d key=%0d empty=%0b",
                                     want.status, want.slot, want.found_key, want.is_empty,
                                     got.status, got.slot, got.found_key, got.is_empty);
                    end
                end
            end
            if (rsp_hold > 0) begin
                rsp_ch.ready <= 1'b0;
                rsp_hold = rsp_hold - 1;
            end else if (!rsp_calm && rsp_ch.ready && $urandom_range(0, 3) == 0) begin
                rsp_ch.ready <= 1'b0;
                rsp_hold = $urandom_range(0, 2);
            end else begin
                rsp_ch.ready <= 1'b1;
            end
        end
    end

    // Stimulus.
    initial begin
        t_row rows [$];
        int pick;
        logic [KEY_W-1:0] k, nk;
        t_kind kd;
        req_ch.valid   <= 1'b0;
        req_ch.kind    <= '0;
        req_ch.key     <= '0;
        req_ch.new_key <= '0;
        req_ch.rank    <= '0;
        table_wipe();
        foreach (key_pool[i]) key_pool[i] = (i < 4) ? i * 7 : $urandom() & 32'h7FFF_FFFF;
        key_pool[4] = 31'h7FFF_FFFF;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part: empty table, extremes, tombstones, change cases, unused kinds.
        rows.push_back(mk(KIND_LOOKUP, 0, 0, 0, 1, STAT_EMPTY));
        rows.push_back(mk(KIND_NTH, 0, 0, 1, 1, STAT_EMPTY));
        rows.push_back(mk(KIND_DELETE, 5, 0, 0, 1, STAT_NOTFOUND));
        rows.push_back(mk(KIND_CHANGE, 5, 6, 0, 1, STAT_NOTFOUND));
        rows.push_back(mk(KIND_INSERT, 0, 0, 0, 1, STAT_OK));
        rows.push_back(mk(KIND_INSERT, 31'h7FFF_FFFF, 0, 0, 1, STAT_OK));
        rows.push_back(mk(KIND_INSERT, 0, 0, 0, 1, STAT_EXISTS));
        rows.push_back(mk(KIND_LOOKUP, 31'h7FFF_FFFF, 0, 0, 0, STAT_OK));
        rows.push_back(mk(KIND_LOOKUP, 12345, 0, 0, 1, STAT_NOTFOUND));
        rows.push_back(mk(KIND_NTH, 0, 0, 0, 1, STAT_NOTFOUND));
        rows.push_back(mk(KIND_NTH, 0, 0, 2, 0, STAT_OK));
        rows.push_back(mk(KIND_NTH, 0, 0, 511, 1, STAT_ERROR));
        rows.push_back(mk(KIND_CHANGE, 0, 0, 0, 1, STAT_EXISTS));
        rows.push_back(mk(KIND_CHANGE, 0, 31'h7FFF_FFFF, 0, 1, STAT_EXISTS));
        rows.push_back(mk(KIND_CHANGE, 0, 99, 0, 1, STAT_OK));
        rows.push_back(mk(KIND_DELETE, 99, 0, 0, 1, STAT_OK));
        rows.push_back(mk(KIND_LOOKUP, 99, 0, 0, 1, STAT_NOTFOUND));
        rows.push_back(mk(KIND_INSERT, 99, 0, 0, 1, STAT_OK));
        rows.push_back(mk(t_kind'(3'd6), 1, 1, 1, 1, STAT_ERROR));
        rows.push_back(mk(t_kind'(3'd7), 31'h7FFF_FFFF, 31'h7FFF_FFFF, 9'h1FF, 1, STAT_ERROR));
        rows.push_back(mk(KIND_CLEAR, 0, 0, 0, 1, STAT_OK));
        rows.push_back(mk(KIND_LOOKUP, 0, 0, 0, 1, STAT_EMPTY));
        foreach (rows[i]) send_request(rows[i], 1'b1);

        // Random part; fill phases mostly insert fresh keys to push the table toward its fill limit.
        for (int n = 0; n < N_RANDOM; n++) begin
            if (n >= N_RANDOM - 100) rsp_calm = 1'b1;
            pick = $urandom_range(0, 99);
            k  = ($urandom_range(0, 2) == 0) ? ($urandom() & 32'h7FFF_FFFF)
                                             : key_pool[$urandom_range(0, 15)];
            nk = ($urandom_range(0, 1) == 0) ? ($urandom() & 32'h7FFF_FFFF)
                                             : key_pool[$urandom_range(0, 15)];
            if (n % 200 < 50 && n >= 100) kd = (pick < 90) ? KIND_INSERT : KIND_NTH;
            else if (pick < 20) kd = KIND_LOOKUP;
            else if (pick < 45) kd = KIND_INSERT;
            else if (pick < 62) kd = KIND_DELETE;
            else if (pick < 77) kd = KIND_CHANGE;
            else if (pick < 95) kd = KIND_NTH;
            else if (pick < 97) kd = KIND_CLEAR;
            else kd = t_kind'(3'($urandom_range(6, 7)));
            if (kd == KIND_INSERT && n % 200 < 50) k = $urandom() & 32'h7FFF_FFFF;
            send_request(mk(kd, k, nk,
                            ($urandom_range(0, 9) == 0) ? $urandom_range(0, 511)
                                                        : $urandom_range(0, tbl_live + 1),
                            1'b0, STAT_OK),
                         !rsp_calm);
        end
        req_ch.valid <= 1'b0;

        // Drain.
        for (int c = 0; c < 200_000 && rsp_expected.size() != 0; c++) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (mismatches == 0 && rsp_expected.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

### filelist.f
rtl/dhkt_pkg.sv
rtl/dhkt_if.sv
rtl/dhkt_ram.sv
rtl/dhkt_hash.sv
rtl/dhkt_datapath.sv
rtl/dhkt_ctrl.sv
rtl/double_hash_key_table.sv
tb/sv/double_hash_key_table_tb.sv
